### src/swrm_pkg.sv
// Shared widths, types and constants of the sliding-window rate meter.
`timescale 1ns / 1ps

package swrm_pkg;

  localparam int unsigned CNT_W   = 32;  // one source counter
  localparam int unsigned TOTAL_W = 34;  // sum of four counters
  localparam int unsigned TIME_W  = 64;  // timestamp
  localparam int unsigned TPS_W   = 32;  // ticks per second
  localparam int unsigned RATE_W  = 32;  // 24.8 rate
  localparam int unsigned FRAC_W  = 8;   // fraction bits of the rate
  localparam int unsigned HALF_W  = 17;  // emitted count split for the multiply
  localparam int unsigned PP_W    = HALF_W + TPS_W;          // partial product
  localparam int unsigned PROD_W  = TOTAL_W + TPS_W;         // full product
  localparam int unsigned DVD_W   = PROD_W + FRAC_W;         // dividend
  localparam int unsigned SUB_W   = TIME_W + 1;              // shared subtractor operand
  localparam int unsigned DIV_CW  = $clog2(RATE_W);          // division step counter

  localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(10000000);
  localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};
  localparam int unsigned       MIN_KEPT  = 2;

  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [RATE_W-1:0]  rate_t;
  typedef logic [TPS_W-1:0]   tps_t;
  typedef logic [CNT_W-1:0]   cnt_t;

endpackage

### src/sliding_window_rate_meter.sv
// Sliding-window event rate meter: sample ring, window trim and 24.8 rate divide.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): one beat carries four cumulative
//   counters and a 64-bit timestamp. The block raises in_stall while it works
//   on a beat, so it holds at most one beat at a time.
//   Result channel (out_valid / out_stall): one beat per input beat with the
//   34-bit counter total and the live rate in unsigned 24.8 fixed point.
//   Config port: cfg_we writes cfg_wdata into ticks_per_second (zero acts as
//   one); write it only while the block is idle.
// Sequence length
//   The time from accept to result grows with E, the samples dropped from
//   the window (0 to SAMPLE_SLOTS-2); the 32-step divider and the ring's
//   read port set it. A zero or saturated rate ends the sequence early.
// Reset
//   rst_n (synchronous) empties the ring and loads ticks_per_second with
//   10000000; ring contents are not cleared, only the fill count and oldest index.
// Stall
//   A finished result waits in the output register while out_stall is high;
//   a new input beat is still taken, and its result waits at the end of the
//   sequence until the output register frees.

module sliding_window_rate_meter #(
  parameter int unsigned SAMPLE_SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [swrm_pkg::TPS_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [swrm_pkg::CNT_W-1:0]   in_clicker0_count,
  input  logic [swrm_pkg::CNT_W-1:0]   in_clicker1_count,
  input  logic [swrm_pkg::CNT_W-1:0]   in_clicker2_count,
  input  logic [swrm_pkg::CNT_W-1:0]   in_clicker3_count,
  input  logic [swrm_pkg::TIME_W-1:0]  in_now_ticks,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [swrm_pkg::TOTAL_W-1:0] out_total_clicks,
  output logic [swrm_pkg::RATE_W-1:0]  out_live_rate
);

  localparam int unsigned IW = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
  localparam int unsigned FW = $clog2(SAMPLE_SLOTS + 1);
  localparam int unsigned SW = FW + 1;  // ring index sum before wrap
  localparam logic [FW-1:0] FULL_CNT = FW'(SAMPLE_SLOTS);
  localparam logic [FW-1:0] KEEP_CNT = FW'(swrm_pkg::MIN_KEPT);
  localparam logic [SW-1:0] WRAP     = SW'(SAMPLE_SLOTS);
  localparam logic [swrm_pkg::DIV_CW-1:0] DIV_LAST =
    swrm_pkg::DIV_CW'(swrm_pkg::RATE_W - 1);

  // sequencer codes
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_WRITE   = 4'd1;
  localparam logic [3:0] ST_EV_CHK  = 4'd2;
  localparam logic [3:0] ST_EV_CMP  = 4'd3;
  localparam logic [3:0] ST_RD_OLD  = 4'd4;
  localparam logic [3:0] ST_RD_NEW  = 4'd5;
  localparam logic [3:0] ST_GET_NEW = 4'd6;
  localparam logic [3:0] ST_SUB_C   = 4'd7;
  localparam logic [3:0] ST_MUL_LO  = 4'd8;
  localparam logic [3:0] ST_MUL_HI  = 4'd9;
  localparam logic [3:0] ST_MUL_SUM = 4'd10;
  localparam logic [3:0] ST_SAT     = 4'd11;
  localparam logic [3:0] ST_DIV     = 4'd12;
  localparam logic [3:0] ST_FINISH  = 4'd13;

  logic [3:0] state_r, state_nxt;

  swrm_pkg::tps_t   cfg_tps_r;
  swrm_pkg::tps_t   tps_r;
  swrm_pkg::time_t  now_r;
  swrm_pkg::total_t total_r;
  logic [IW-1:0]    oldest_r;
  logic [FW-1:0]    filled_r;

  // sample ring
  swrm_pkg::time_t  times_mem  [SAMPLE_SLOTS];
  swrm_pkg::total_t totals_mem [SAMPLE_SLOTS];
  swrm_pkg::time_t  time_q_r;
  swrm_pkg::total_t total_q_r;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    wr_addr;
  logic             wr_en;

  // rate datapath
  swrm_pkg::time_t  old_t_r;
  swrm_pkg::total_t old_c_r;
  swrm_pkg::total_t new_c_r;
  swrm_pkg::time_t  elapsed_r;
  swrm_pkg::total_t emitted_r;
  logic [swrm_pkg::PP_W-1:0] pp_lo_r;
  logic [swrm_pkg::PP_W-1:0] pp_hi_r;
  swrm_pkg::time_t  rem_r;
  swrm_pkg::rate_t  quo_r;
  logic [swrm_pkg::DIV_CW-1:0] step_r;
  swrm_pkg::rate_t  rate_r;

  logic                          out_valid_r;
  swrm_pkg::total_t              out_total_r;
  swrm_pkg::rate_t               out_rate_r;

  // shared subtractor: the time and count differences, the saturation check and the divide steps run here
  logic [swrm_pkg::SUB_W-1:0] sub_a, sub_b;
  logic [swrm_pkg::SUB_W:0]   sub_res;
  logic                       sub_borrow;

  logic                       in_acc;
  logic                       out_free;
  logic [SW-1:0]              wr_sum, new_sum;
  logic [IW-1:0]              newest_idx;
  logic [IW-1:0]              oldest_inc;
  logic [swrm_pkg::PROD_W-1:0] prod;
  logic [swrm_pkg::DVD_W-1:0]  dvd;
  logic [swrm_pkg::SUB_W-1:0]  div_cand;
  logic                        quo_bit;
  logic [swrm_pkg::TOTAL_W-1:0] in_sum;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign in_sum = swrm_pkg::TOTAL_W'(in_clicker0_count) + swrm_pkg::TOTAL_W'(in_clicker1_count)
                + swrm_pkg::TOTAL_W'(in_clicker2_count) + swrm_pkg::TOTAL_W'(in_clicker3_count);

  // ring index arithmetic: sums stay below twice the depth, one compare wraps
  assign oldest_inc = (oldest_r == IW'(SAMPLE_SLOTS - 1)) ? '0 : oldest_r + 1'b1;
  assign wr_sum     = SW'(oldest_r) + SW'(filled_r);
  assign wr_addr    = (wr_sum >= WRAP) ? IW'(wr_sum - WRAP) : IW'(wr_sum);
  assign new_sum    = SW'(oldest_r) + SW'(filled_r) - 1'b1;
  assign newest_idx = (new_sum >= WRAP) ? IW'(new_sum - WRAP) : IW'(new_sum);
  assign wr_en      = (state_r == ST_WRITE);

  always_comb begin
    case (state_r)
      ST_RD_NEW: rd_addr = newest_idx;
      default:   rd_addr = oldest_r;
    endcase
  end

  assign prod     = swrm_pkg::PROD_W'(pp_lo_r) + (swrm_pkg::PROD_W'(pp_hi_r) << swrm_pkg::HALF_W);
  assign dvd      = {prod, swrm_pkg::FRAC_W'(0)};
  assign div_cand = {rem_r, quo_r[swrm_pkg::RATE_W-1]};

  always_comb begin
    case (state_r)
      ST_EV_CMP: begin
        sub_a = {1'b0, now_r};
        sub_b = {1'b0, time_q_r};
      end
      ST_GET_NEW: begin
        sub_a = {1'b0, time_q_r};
        sub_b = {1'b0, old_t_r};
      end
      ST_SUB_C: begin
        sub_a = swrm_pkg::SUB_W'(new_c_r);
        sub_b = swrm_pkg::SUB_W'(old_c_r);
      end
      ST_SAT: begin
        sub_a = {1'b0, rem_r};
        sub_b = {1'b0, elapsed_r};
      end
      ST_DIV: begin
        sub_a = div_cand;
        sub_b = {1'b0, elapsed_r};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_res[swrm_pkg::SUB_W];
  assign quo_bit    = !sub_borrow;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_acc) state_nxt = ST_WRITE;
      ST_WRITE:   state_nxt = ST_EV_CHK;
      ST_EV_CHK: begin
        if (filled_r > KEEP_CNT) state_nxt = ST_EV_CMP;
        else if (filled_r == KEEP_CNT) state_nxt = ST_RD_OLD;
        else state_nxt = ST_FINISH;
      end
      ST_EV_CMP: begin
        if (sub_res[swrm_pkg::TIME_W-1:0] > swrm_pkg::TIME_W'(tps_r)) state_nxt = ST_EV_CHK;
        else state_nxt = ST_RD_OLD;
      end
      ST_RD_OLD:  state_nxt = ST_RD_NEW;
      ST_RD_NEW:  state_nxt = ST_GET_NEW;
      ST_GET_NEW: state_nxt = ST_SUB_C;
      ST_SUB_C: begin
        if (sub_borrow || sub_res[swrm_pkg::TOTAL_W-1:0] == '0 || elapsed_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO:  state_nxt = ST_MUL_HI;
      ST_MUL_HI:  state_nxt = ST_MUL_SUM;
      ST_MUL_SUM: state_nxt = ST_SAT;
      ST_SAT:     state_nxt = sub_borrow ? ST_DIV : ST_FINISH;
      ST_DIV:     if (step_r == DIV_LAST) state_nxt = ST_FINISH;
      ST_FINISH:  if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_tps_r   <= swrm_pkg::TPS_RESET;
      oldest_r    <= '0;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cfg_tps_r <= cfg_wdata;
      case (state_r)
        ST_IDLE: begin
          // ring full: drop the oldest sample to make room
          if (in_acc && filled_r >= FULL_CNT) begin
            oldest_r <= oldest_inc;
            filled_r <= FULL_CNT - 1'b1;
          end
        end
        ST_WRITE: filled_r <= filled_r + 1'b1;
        ST_EV_CMP: begin
          if (sub_res[swrm_pkg::TIME_W-1:0] > swrm_pkg::TIME_W'(tps_r)) begin
            oldest_r <= oldest_inc;
            filled_r <= filled_r - 1'b1;
          end
        end
        default: ;
      endcase
      if (state_r == ST_FINISH && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // sample ring, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      times_mem[wr_addr]  <= now_r;
      totals_mem[wr_addr] <= total_r;
    end
    time_q_r  <= times_mem[rd_addr];
    total_q_r <= totals_mem[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          total_r <= in_sum;
          now_r   <= in_now_ticks;
          tps_r   <= (cfg_tps_r == '0) ? swrm_pkg::TPS_W'(1) : cfg_tps_r;
          rate_r  <= '0;
        end
      end
      ST_RD_NEW: begin
        old_t_r <= time_q_r;
        old_c_r <= total_q_r;
      end
      ST_GET_NEW: begin
        elapsed_r <= sub_res[swrm_pkg::TIME_W-1:0];
        new_c_r   <= total_q_r;
      end
      ST_SUB_C:   emitted_r <= sub_res[swrm_pkg::TOTAL_W-1:0];
      ST_MUL_LO:  pp_lo_r <= swrm_pkg::PP_W'(emitted_r[swrm_pkg::HALF_W-1:0])
                           * swrm_pkg::PP_W'(tps_r);
      ST_MUL_HI:  pp_hi_r <= swrm_pkg::PP_W'(emitted_r[swrm_pkg::TOTAL_W-1:swrm_pkg::HALF_W])
                           * swrm_pkg::PP_W'(tps_r);
      ST_MUL_SUM: begin
        // upper dividend bits seed the remainder; lower bits feed the quotient shifter
        rem_r  <= swrm_pkg::TIME_W'(dvd[swrm_pkg::DVD_W-1:swrm_pkg::RATE_W]);
        quo_r  <= dvd[swrm_pkg::RATE_W-1:0];
        step_r <= '0;
      end
      ST_SAT: begin
        // upper part not below the divisor: quotient exceeds 32 bits
        if (!sub_borrow) rate_r <= swrm_pkg::RATE_MAX;
      end
      ST_DIV: begin
        if (quo_bit) rem_r <= sub_res[swrm_pkg::TIME_W-1:0];
        else rem_r <= div_cand[swrm_pkg::TIME_W-1:0];
        quo_r  <= {quo_r[swrm_pkg::RATE_W-2:0], quo_bit};
        step_r <= step_r + 1'b1;
        if (step_r == DIV_LAST) rate_r <= {quo_r[swrm_pkg::RATE_W-2:0], quo_bit};
      end
      ST_FINISH: begin
        if (out_free) begin
          out_total_r <= total_r;
          out_rate_r  <= rate_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_total_clicks = out_total_r;
  assign out_live_rate    = out_rate_r;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= FULL_CNT)
    else $error("fill count beyond ring depth");

  a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oldest_r <= IW'(SAMPLE_SLOTS - 1))
    else $error("oldest index outside ring");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && filled_r < FULL_CNT + 1'b1)
    else $error("not busy after accepting a beat");

  a_window_keeps_two: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD_OLD |-> filled_r >= KEEP_CNT)
    else $error("rate read with fewer than two samples");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_rate_r))
    else $error("waiting result lost");

endmodule

### tb/tb_sliding_window_rate_meter.sv
// Self-checking testbench of the sliding-window rate meter: directed table plus random updates.
`timescale 1ns / 1ps

module tb_sliding_window_rate_meter;

  localparam int          SLOTS       = 16;    // ring depth of the block under test
  localparam int unsigned QUIET_LIMIT = 4000;  // cycles without any beat before giving up
  localparam int unsigned LONG_HOLD   = 600;   // receiver hold-off that fills the block
  localparam int unsigned PHASE_ITEMS = 100;   // random updates per window setting
  localparam int unsigned TAIL_CYCLES = 100;   // drain time once nothing is pending
  localparam int unsigned MAX_GAP     = 17;    // longest random idle of either side

  // One result beat: counter total and 24.8 rate.
  typedef struct packed {
    swrm_pkg::total_t total;
    swrm_pkg::rate_t  rate;
  } meter_reading_t;

  // One update beat; known rows carry a reading typed in by hand.
  typedef struct {
    swrm_pkg::cnt_t  c0, c1, c2, c3;
    swrm_pkg::time_t now;
    bit              known;
    meter_reading_t  want;
  } update_row_t;

  logic             clk               = 1'b0;
  logic             rst_n             = 1'b0;
  logic             cfg_we            = 1'b0;
  swrm_pkg::tps_t   cfg_wdata         = '0;
  logic             in_valid          = 1'b0;
  logic             in_stall;
  swrm_pkg::cnt_t   in_clicker0_count = '0;
  swrm_pkg::cnt_t   in_clicker1_count = '0;
  swrm_pkg::cnt_t   in_clicker2_count = '0;
  swrm_pkg::cnt_t   in_clicker3_count = '0;
  swrm_pkg::time_t  in_now_ticks      = '0;
  logic             out_valid;
  logic             out_stall         = 1'b0;
  swrm_pkg::total_t out_total_clicks;
  swrm_pkg::rate_t  out_live_rate;

  // Predictor state: a private copy of the ring, its pointers and the window register.
  swrm_pkg::time_t  ring_time  [SLOTS];
  swrm_pkg::total_t ring_total [SLOTS];
  int unsigned      head_slot;
  int unsigned      live_slots;
  swrm_pkg::tps_t   span_setting;

  // Running counters and clock of the random traffic.
  swrm_pkg::time_t run_now;
  swrm_pkg::cnt_t  run_cnt [4];

  meter_reading_t expected_readings [$];
  update_row_t    directed_rows [$];
  int unsigned    mismatches  = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    sent_beats   = 0;
  bit             hold_req     = 1'b0;

  sliding_window_rate_meter #(
    .SAMPLE_SLOTS(SLOTS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_clicker0_count(in_clicker0_count),
    .in_clicker1_count(in_clicker1_count),
    .in_clicker2_count(in_clicker2_count),
    .in_clicker3_count(in_clicker3_count),
    .in_now_ticks     (in_now_ticks),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_total_clicks (out_total_clicks),
    .out_live_rate    (out_live_rate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Advance the meter by one update: append the sample, trim the window, derive the rate.
  function automatic void advance_meter(input swrm_pkg::cnt_t c0, input swrm_pkg::cnt_t c1,
                                        input swrm_pkg::cnt_t c2, input swrm_pkg::cnt_t c3,
                                        input swrm_pkg::time_t now,
                                        output meter_reading_t reading);
    swrm_pkg::time_t  span;
    swrm_pkg::time_t  elapsed;
    swrm_pkg::total_t sum;
    swrm_pkg::total_t gained;
    logic [127:0]     scaled;
    logic [127:0]     quo;
    int unsigned      slot;
    int unsigned      newest;
    // A zero window register behaves as one tick per second.
    span = (span_setting == '0) ? 64'd1 : 64'(span_setting);
    sum  = swrm_pkg::total_t'(c0) + swrm_pkg::total_t'(c1)
         + swrm_pkg::total_t'(c2) + swrm_pkg::total_t'(c3);
    reading.total = sum;
    reading.rate  = '0;
    // Full ring: evict the oldest entry to make room.
    if (live_slots >= SLOTS) begin
      head_slot  = (head_slot + 1) % SLOTS;
      live_slots = SLOTS - 1;
    end
    slot = (head_slot + live_slots) % SLOTS;
    ring_time[slot]  = now;
    ring_total[slot] = sum;
    live_slots++;
    // Drop stale samples, but never below the two needed for a rate.
    while (live_slots > swrm_pkg::MIN_KEPT && (now - ring_time[head_slot]) > span) begin
      head_slot = (head_slot + 1) % SLOTS;
      live_slots--;
    end
    if (live_slots >= swrm_pkg::MIN_KEPT) begin
      newest  = (head_slot + live_slots - 1) % SLOTS;
      elapsed = ring_time[newest] - ring_time[head_slot];
      gained  = (ring_total[newest] >= ring_total[head_slot]) ?
                ring_total[newest] - ring_total[head_slot] : '0;
      // Zero elapsed time or no gain leaves the rate at zero.
      if (elapsed != '0 && gained != '0) begin
        scaled = (128'(gained) * 128'(span)) << swrm_pkg::FRAC_W;
        quo    = scaled / 128'(elapsed);
        reading.rate = (quo > 128'(swrm_pkg::RATE_MAX)) ? swrm_pkg::RATE_MAX :
                       quo[swrm_pkg::RATE_W-1:0];
      end
    end
  endfunction

  function automatic void add_row(input swrm_pkg::cnt_t c0, input swrm_pkg::cnt_t c1,
                                  input swrm_pkg::cnt_t c2, input swrm_pkg::cnt_t c3,
                                  input swrm_pkg::time_t now, input bit known,
                                  input swrm_pkg::total_t total, input swrm_pkg::rate_t rate);
    update_row_t row;
    row.c0 = c0;
    row.c1 = c1;
    row.c2 = c2;
    row.c3 = c3;
    row.now = now;
    row.known = known;
    row.want.total = total;
    row.want.rate  = rate;
    directed_rows.push_back(row);
  endfunction

  // Directed table, walked right after reset with the default window of 10000000 ticks.
  function automatic void load_directed();
    int unsigned k;
    // First sample alone: no rate yet.
    add_row('0, '0, '0, '0, 64'd0, 1'b1, 34'd0, 32'd0);
    // All counters at maximum, same timestamp: zero elapsed time.
    add_row('1, '1, '1, '1, 64'd0, 1'b1, 34'h3_FFFF_FFFC, 32'd0);
    // Huge gain over one tick: saturate.
    add_row('1, '1, '1, '1, 64'd1, 1'b1, 34'h3_FFFF_FFFC, swrm_pkg::RATE_MAX);
    // Two seconds later with all counters at zero: window trimmed, total fell, no rate.
    add_row('0, '0, '0, '0, 64'd20_000_000, 1'b1, 34'd0, 32'd0);
    // Timestamp near the top of the range, then wrap past zero.
    add_row(32'd1, 32'd2, 32'd3, 32'd4, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, '0, '0);
    add_row(32'd5, 32'd6, 32'd7, 32'd8, 64'h10, 1'b0, '0, '0);
    // Dense updates inside one window: fill the ring and force evictions.
    for (k = 1; k <= 18; k++)
      add_row(swrm_pkg::cnt_t'(k * 100), swrm_pkg::cnt_t'(k * 7), 32'd3, swrm_pkg::cnt_t'(k),
              64'h10 + 64'(k) * 64'd1000, 1'b0, '0, '0);
  endfunction

  // Draw the next random update: mostly an advancing clock and growing counters.
  function automatic update_row_t draw_update();
    update_row_t    row;
    swrm_pkg::tps_t span32;
    int unsigned    mode;
    int unsigned    k;
    span32 = (span_setting == '0) ? 32'd1 : span_setting;
    mode   = $urandom_range(0, 19);
    case (mode)
      0, 1: ;                                          // hold the clock: zero elapsed
      2, 3: run_now += 64'(span32) + 64'($urandom_range(1, span32));  // past the window
      4:    run_now = {$urandom, $urandom};            // jump anywhere
      default: run_now += 64'($urandom_range(1, span32 / 8 + 1));
    endcase
    for (k = 0; k < 4; k++) begin
      mode = $urandom_range(0, 19);
      if (mode == 0) run_cnt[k] = $urandom;
      else if (mode == 1) run_cnt[k] = run_cnt[k] - swrm_pkg::cnt_t'($urandom_range(0, 500));
      else if (mode == 2) run_cnt[k] = run_cnt[k] + swrm_pkg::cnt_t'($urandom);
      else run_cnt[k] = run_cnt[k] + swrm_pkg::cnt_t'($urandom_range(0, 2000));
    end
    row.c0 = run_cnt[0];
    row.c1 = run_cnt[1];
    row.c2 = run_cnt[2];
    row.c3 = run_cnt[3];
    row.now = run_now;
    row.known = 1'b0;
    row.want = '0;
    return row;
  endfunction

  // Offer one update beat after an idle gap, hold it until accepted, queue its reading.
  task automatic offer_update(input update_row_t row, input int unsigned gap);
    meter_reading_t reading;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_clicker0_count <= row.c0;
    in_clicker1_count <= row.c1;
    in_clicker2_count <= row.c2;
    in_clicker3_count <= row.c3;
    in_now_ticks      <= row.now;
    do @(posedge clk); while (in_stall);
    advance_meter(row.c0, row.c1, row.c2, row.c3, row.now, reading);
    expected_readings.push_back(row.known ? row.want : reading);
    sent_beats++;
  endtask

  // Every few dozen beats the sender runs without idling.
  function automatic int unsigned sender_gap();
    return ((sent_beats / 40) % 4 == 1) ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Drain, then write the window register while the block is idle.
  task automatic set_window(input swrm_pkg::tps_t ticks);
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    span_setting = ticks;
  endtask

  // Compare one accepted result beat with the oldest pending reading.
  task automatic check_reading();
    meter_reading_t want;
    if (expected_readings.size() == 0) begin
      flag_mismatch($sformatf("result beat total=%0d rate=%0h with nothing pending",
                              out_total_clicks, out_live_rate));
      return;
    end
    want = expected_readings.pop_front();
    if (out_total_clicks !== want.total)
      flag_mismatch($sformatf("total_clicks %0d, expected %0d", out_total_clicks, want.total));
    if (out_live_rate !== want.rate)
      flag_mismatch($sformatf("live_rate %08h, expected %08h", out_live_rate, want.rate));
  endtask

  // Sender: reset, directed table, then one random phase per window setting.
  initial begin : update_source
    int unsigned    phase;
    int unsigned    n;
    swrm_pkg::tps_t ticks;
    head_slot    = 0;
    live_slots   = 0;
    span_setting = swrm_pkg::TPS_RESET;
    foreach (ring_time[i]) begin
      ring_time[i]  = '0;
      ring_total[i] = '0;
    end
    load_directed();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) offer_update(directed_rows[i], sender_gap());

    for (phase = 0; phase < 5; phase++) begin
      // Sweep the window: one tick, zero (acts as one), maximum, short, random.
      case (phase)
        0:       ticks = 32'd1;
        1:       ticks = 32'd0;
        2:       ticks = 32'hFFFF_FFFF;
        3:       ticks = 32'd1000;
        default: ticks = swrm_pkg::tps_t'($urandom_range(2, 50_000_000));
      endcase
      set_window(ticks);
      run_now = {$urandom, $urandom};
      for (n = 0; n < 4; n++) run_cnt[n] = $urandom;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Ask the receiver for one long hold-off mid-run so the block backs up.
        if (phase == 2 && n == 30) hold_req = 1'b1;
        offer_update(draw_update(), sender_gap());
      end
    end

    // Wait out every pending reading, then let the block settle.
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sliding_window_rate_meter test passed");
    end else begin
      $display("sliding_window_rate_meter test failed");
    end
    $finish;
  end

  // Receiver: stall a random number of cycles before each result beat, then take it.
  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    forever begin
      if (hold_req) begin
        hold     = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        // Every few dozen beats take results back to back.
        hold = ((taken / 40) % 4 == 2) ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rst_n && out_valid));
      check_reading();
      taken++;
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sliding_window_rate_meter test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
